/* rtl/swsup_pkg.sv */
// Shared types and register codes for the sync window supervisor.
`default_nettype none

package swsup_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned ADDR_W = 4;

    typedef logic [TIME_W-1:0] t_ms;
    typedef logic [TIME_W:0]   t_ms_wide;

    typedef enum logic [2:0] {
        EV_WAITING      = 3'd0,
        EV_CONNECTED    = 3'd1,
        EV_WRITTEN      = 3'd2,
        EV_COMPLETED    = 3'd3,
        EV_DISCONNECTED = 3'd4,
        EV_TIMED_OUT    = 3'd5,
        EV_CAPPED       = 3'd6,
        EV_NOTED        = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        REG_ADVERTISE = 2'd0,
        REG_IDLE      = 2'd1,
        REG_CAP       = 2'd2
    } t_reg_idx;

    typedef enum logic {
        CMD_POLL  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        t_ms  now_ms;
        logic sig_connected;
        logic sig_time_written;
        logic sig_disconnected;
        logic write_ok;
    } t_item;

    typedef struct packed {
        t_event event_res;
        t_ms    wait_ms;
        logic   window_ended;
    } t_result;

    typedef struct packed {
        t_ms advertise_timeout_ms;
        t_ms idle_timeout_ms;
        t_ms session_cap_ms;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/swsup_in_if.sv */
// Input item channel: valid, ready and the poll or write-result payload.
`default_nettype none

interface swsup_in_if import swsup_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/swsup_out_if.sv */
// Result channel: valid, ready and the classified event payload.
`default_nettype none

interface swsup_out_if import swsup_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/sync_window_supervisor.sv */
// Top level of the sync window supervisor: channel registers, config and core.
//
//   channel   role     direction  payload
//   i_item    sink     in         cmd, now_ms, sig_*, write_ok
//   o_result  source   out        event_res, wait_ms, window_ended
//   apb       slave    in/out     three 32-bit registers at 0x0, 0x4, 0x8
//
// One item per cycle sustained while results are accepted by the sink.
// Cycle: input register, classify and wait-time logic, result register.
// i_rst_n is synchronous; it clears the channel valid flags and session state.
// A held result stalls the input register only when that register is full.
`default_nettype none

module sync_window_supervisor import swsup_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    swsup_in_if.sink               i_item,
    swsup_out_if.source            o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    w_advance;
    t_cfg    w_cfg;
    t_result w_res;

    swsup_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    swsup_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

    assign w_advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready     = !r_in_valid || w_advance;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.payload;
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    a_ended_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.window_ended |-> r_out.wait_ms == '0)
        else $error("ended window reports nonzero wait");

    a_write_noted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && r_in.cmd == CMD_WRITE |=> r_out_valid && r_out.event_res == EV_NOTED)
        else $error("write-result transfer not reported as noted");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in))
        else $error("stalled input register changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result.ready |=> r_out_valid && $stable(r_out))
        else $error("unaccepted result changed");

endmodule

`default_nettype wire

/* rtl/swsup_cfg.sv */
// APB configuration registers for the timeouts and the session cap.
`default_nettype none

module swsup_cfg import swsup_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.advertise_timeout_ms <= t_ms'(6000);
            r_cfg.idle_timeout_ms      <= t_ms'(4000);
            r_cfg.session_cap_ms       <= t_ms'(12000);
        end else if (w_wr) begin
            case (w_idx)
                REG_ADVERTISE: r_cfg.advertise_timeout_ms <= pwdata;
                REG_IDLE:      r_cfg.idle_timeout_ms      <= pwdata;
                REG_CAP:       r_cfg.session_cap_ms       <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ADVERTISE: prdata = r_cfg.advertise_timeout_ms;
            REG_IDLE:      prdata = r_cfg.idle_timeout_ms;
            REG_CAP:       prdata = r_cfg.session_cap_ms;
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/swsup_core.sv */
// Session state and the one-step classify and wait-time logic.
`default_nettype none

module swsup_core import swsup_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    logic   r_is_connected;
    logic   r_window_over;
    t_event r_final_event;
    logic   r_exchange_done;
    t_ms    r_phase_start_ms;

    logic   n_is_connected;
    logic   n_window_over;
    t_event n_final_event;
    logic   n_exchange_done;
    t_ms    n_phase_start_ms;

    t_event   w_event;
    logic     w_restart;
    t_ms      w_lim_old;
    t_ms      w_lim_new;
    t_ms_wide w_now;
    t_ms_wide w_cap;
    t_ms_wide w_dl_old;
    t_ms_wide w_dl_now;
    t_ms_wide w_dl_new;
    t_ms_wide w_dl_min;
    t_ms_wide w_left;

    assign w_now     = {1'b0, i_item.now_ms};
    assign w_cap     = {1'b0, i_cfg.session_cap_ms};
    assign w_lim_old = r_is_connected ? i_cfg.idle_timeout_ms : i_cfg.advertise_timeout_ms;
    assign w_lim_new = n_is_connected ? i_cfg.idle_timeout_ms : i_cfg.advertise_timeout_ms;
    assign w_dl_old  = {1'b0, r_phase_start_ms} + {1'b0, w_lim_old};
    assign w_dl_now  = w_now + {1'b0, w_lim_new};

    always_comb begin
        n_is_connected   = r_is_connected;
        n_window_over    = r_window_over;
        n_final_event    = r_final_event;
        n_exchange_done  = r_exchange_done;
        n_phase_start_ms = r_phase_start_ms;
        w_restart        = 1'b0;
        w_event          = EV_WAITING;
        priority if (i_item.cmd == CMD_WRITE) begin
            if (i_item.write_ok) begin
                n_exchange_done = 1'b1;
            end
            w_event = EV_NOTED;
        end else if (r_window_over) begin
            w_event = r_final_event;
        end else if (w_now >= w_cap) begin
            w_event = EV_CAPPED;
        end else if (!r_is_connected && i_item.sig_connected) begin
            n_is_connected   = 1'b1;
            n_phase_start_ms = i_item.now_ms;
            w_restart        = 1'b1;
            w_event          = EV_CONNECTED;
        end else if (i_item.sig_time_written) begin
            if (r_exchange_done) begin
                w_event = EV_COMPLETED;
            end else begin
                n_phase_start_ms = i_item.now_ms;
                w_restart        = 1'b1;
                w_event          = EV_WRITTEN;
            end
        end else if (i_item.sig_disconnected) begin
            w_event = EV_DISCONNECTED;
        end else if (w_now >= w_dl_old) begin
            w_event = EV_TIMED_OUT;
        end else begin
            w_event = EV_WAITING;
        end
        if (i_item.cmd == CMD_POLL && !r_window_over &&
            (w_event == EV_CAPPED || w_event == EV_COMPLETED ||
             w_event == EV_DISCONNECTED || w_event == EV_TIMED_OUT)) begin
            n_window_over = 1'b1;
            n_final_event = w_event;
        end
    end

    assign w_dl_new = w_restart ? w_dl_now : w_dl_old;
    assign w_dl_min = (w_cap < w_dl_new) ? w_cap : w_dl_new;
    assign w_left   = (n_window_over || w_now >= w_dl_min) ? '0 : (w_dl_min - w_now);

    assign o_result.event_res    = w_event;
    assign o_result.wait_ms      = w_left[TIME_W-1:0];
    assign o_result.window_ended = n_window_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_connected   <= 1'b0;
            r_window_over    <= 1'b0;
            r_exchange_done  <= 1'b0;
            r_phase_start_ms <= '0;
        end else if (i_step) begin
            r_is_connected   <= n_is_connected;
            r_window_over    <= n_window_over;
            r_exchange_done  <= n_exchange_done;
            r_phase_start_ms <= n_phase_start_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_final_event <= n_final_event;
        end
    end

endmodule

`default_nettype wire
